### rtl/segment_convex_polygon_clip_macros.svh
// assertion macros for the clipper checker
`ifndef SEGMENT_CONVEX_POLYGON_CLIP_MACROS_SVH
`define SEGMENT_CONVEX_POLYGON_CLIP_MACROS_SVH

`define SCPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SCPC_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/scpc_pkg.sv
package scpc_pkg;

    localparam int MaxVerticesDef = 64;
    localparam int CoordBitsDef   = 16;
    localparam int TBits          = 18;
    localparam int TOne           = 65536;
    localparam int TSat           = 131072;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_CLIP   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

endpackage

### rtl/segment_convex_polygon_clip.sv
// clear and append are taken from idle and can follow each other every cycle
// a clip walks each edge with the shared multiplier and the 53-step serial divider,
// where a parallel edge skips the divide, then rounds the four points one by one
// the result strobe ends each clip, sooner on an early no hit or an empty polygon;
// the next item is taken in the cycle after the strobe
// i_rst_n is synchronous, active low; it empties the polygon, the store keeps its data
module segment_convex_polygon_clip
    import scpc_pkg::*;
#(
    parameter int MAX_VERTICES = MaxVerticesDef,
    parameter int COORD_BITS   = CoordBitsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_opcode,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic signed [COORD_BITS-1:0] o_enter_x,
    output logic signed [COORD_BITS-1:0] o_enter_y,
    output logic signed [COORD_BITS-1:0] o_leave_x,
    output logic signed [COORD_BITS-1:0] o_leave_y
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW + 2;
    localparam int NW = PW + 17;
    localparam int QW = TBits;
    localparam int DIVW = NW;
    localparam int MW = (DW + 1 > QW + 1) ? DW + 1 : QW + 1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RD0   = 11'b00000000010,
        S_RD1   = 11'b00000000100,
        S_MUL   = 11'b00000001000,
        S_SUM   = 11'b00000010000,
        S_DIV   = 11'b00000100000,
        S_UPD   = 11'b00001000000,
        S_PMUL  = 11'b00010000000,
        S_PRND  = 11'b00100000000,
        S_OUT   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    logic [2*COORD_BITS-1:0] r_mem [MAX_VERTICES];
    logic [2*COORD_BITS-1:0] r_rd;
    logic [AW-1:0]           r_rd_addr;
    logic [CW-1:0]           r_count;
    t_state                  r_state;
    logic [CW-1:0]           r_idx;
    logic signed [COORD_BITS-1:0] r_x0, r_y0;
    logic signed [COORD_BITS-1:0] r_vx, r_vy, r_fx, r_fy;
    logic signed [DW:0]      r_dx, r_dy;
    logic [1:0]              r_mstep;
    logic signed [PW-1:0]    r_p [4];
    logic signed [PW-1:0]    r_num, r_den;
    logic [DIVW-1:0]         r_rem, r_quo;
    logic [$clog2(DIVW+1)-1:0] r_dcnt;
    logic signed [QW:0]      r_te, r_tl;
    logic                    r_hit;
    logic [1:0]              r_pt;
    logic signed [COORD_BITS-1:0] r_res [4];

    logic [AW-1:0] w_next;
    logic          w_last;

    assign busy   = (r_state != S_IDLE);
    assign w_last = (r_idx == r_count - CW'(1));
    assign w_next = w_last ? AW'(0) : AW'(r_idx + CW'(1));

    // shared multiplier
    logic signed [MW-1:0]   w_ma, w_mb;
    logic signed [2*MW-1:0] w_prod;
    logic signed [PW-1:0]   w_mp;
    logic signed [COORD_BITS+QW+2:0] w_pp;
    logic signed [DW:0]     w_pd;
    logic signed [QW:0]     w_pt;

    always_comb begin
        w_pd = r_pt[0] ? r_dy : r_dx;
        w_pt = r_pt[1] ? r_tl : r_te;
        w_ma = '0;
        w_mb = '0;
        if (r_state == S_PMUL || r_state == S_PRND) begin
            w_ma = MW'(w_pd);
            w_mb = MW'(w_pt);
        end else begin
            unique case (r_mstep)
                2'd0: begin
                    w_ma = MW'(r_fx) - MW'(r_vx);
                    w_mb = MW'(r_y0) - MW'(r_vy);
                end
                2'd1: begin
                    w_ma = MW'(r_fy) - MW'(r_vy);
                    w_mb = MW'(r_x0) - MW'(r_vx);
                end
                2'd2: begin
                    w_ma = MW'(r_fx) - MW'(r_vx);
                    w_mb = MW'(r_dy);
                end
                default: begin
                    w_ma = MW'(r_fy) - MW'(r_vy);
                    w_mb = MW'(r_dx);
                end
            endcase
        end
        w_prod = w_ma * w_mb;
        w_mp   = PW'(w_prod);
        w_pp   = (COORD_BITS+QW+3)'(w_prod);
    end

    logic [PW-1:0]   w_an, w_ad;
    logic [DIVW:0]   w_sub;
    logic [DIVW-1:0] w_rsh;
    logic [QW-1:0]   w_qs;
    logic signed [QW:0] w_t;
    logic            w_neg;

    always_comb begin
        w_an  = r_num[PW-1] ? PW'(-r_num) : PW'(r_num);
        w_ad  = r_den[PW-1] ? PW'(-r_den) : PW'(r_den);
        w_rsh = {r_rem[DIVW-2:0], r_quo[DIVW-1]};
        w_sub = {1'b0, w_rsh} - (DIVW+1)'(w_ad);
        w_qs  = (r_quo > DIVW'(TSat)) ? QW'(TSat) : QW'(r_quo);
        w_neg = r_num[PW-1] ^ r_den[PW-1];
        w_t   = w_neg ? -(QW+1)'({1'b0, w_qs}) : (QW+1)'({1'b0, w_qs});
    end

    logic [COORD_BITS+QW+2:0] w_pm;
    logic [COORD_BITS+QW+2:0] w_pr;
    logic signed [COORD_BITS-1:0] w_base;
    always_comb begin
        w_pm   = w_pp[COORD_BITS+QW+2] ? -w_pp : w_pp;
        w_pr   = (w_pm + (COORD_BITS+QW+3)'(32768)) >> 16;
        w_base = r_pt[0] ? r_y0 : r_x0;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start && t_opcode'(i_opcode) == OP_APPEND
            && r_count < CW'(MAX_VERTICES))
            r_mem[r_count[AW-1:0]] <= {i_start_y, i_start_x};
        r_rd <= r_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        unique case (t_opcode'(i_opcode))
                            OP_CLEAR:  r_count <= '0;
                            OP_APPEND: if (r_count < CW'(MAX_VERTICES))
                                r_count <= r_count + CW'(1);
                            OP_CLIP: begin
                                r_x0 <= i_start_x; r_y0 <= i_start_y;
                                r_dx <= (DW+1)'(i_end_x) - (DW+1)'(i_start_x);
                                r_dy <= (DW+1)'(i_end_y) - (DW+1)'(i_start_y);
                                r_te <= '0;
                                r_tl <= (QW+1)'(TOne);
                                r_idx <= '0;
                                r_rd_addr <= '0;
                                if (r_count == '0) begin
                                    r_hit <= 1'b0;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_RD0;
                                end
                            end
                            OP_NONE: ;
                        endcase
                    end
                end
                S_RD0: begin
                    r_rd_addr <= w_next;
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_vx <= r_rd[COORD_BITS-1:0];
                    r_vy <= r_rd[2*COORD_BITS-1:COORD_BITS];
                    r_state <= S_MUL;
                    r_mstep <= '0;
                end
                S_MUL: begin
                    if (r_mstep == 2'd0) begin
                        r_fx <= r_rd[COORD_BITS-1:0];
                        r_fy <= r_rd[2*COORD_BITS-1:COORD_BITS];
                        r_mstep <= 2'd0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_p[r_mstep] <= w_mp;
                    r_mstep <= r_mstep + 2'd1;
                    if (r_mstep == 2'd3) begin
                        r_state <= S_DIV;
                        r_dcnt <= '0;
                    end
                end
                S_DIV: begin
                    if (r_dcnt == '0) begin
                        r_num <= r_p[0] - r_p[1];
                        r_den <= r_p[3] - r_p[2];
                        r_dcnt <= r_dcnt + 1'b1;
                    end else if (r_dcnt == 1) begin
                        if (r_den == '0) begin
                            if (r_num[PW-1]) begin
                                r_hit <= 1'b0;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_UPD;
                            end
                        end else begin
                            r_rem <= DIVW'(w_ad >> 1);
                            r_quo <= DIVW'({w_an, 16'd0});
                            r_dcnt <= r_dcnt + 1'b1;
                        end
                    end else if (r_dcnt == 2) begin
                        // fold the half-divisor rounding in: numerator + ad/2
                        r_quo <= r_quo + r_rem;
                        r_rem <= '0;
                        r_dcnt <= r_dcnt + 1'b1;
                    end else if (r_dcnt < DIVW + 3) begin
                        if (!w_sub[DIVW]) begin
                            r_rem <= w_sub[DIVW-1:0];
                            r_quo <= {r_quo[DIVW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rsh;
                            r_quo <= {r_quo[DIVW-2:0], 1'b0};
                        end
                        r_dcnt <= r_dcnt + 1'b1;
                    end else begin
                        if (r_den[PW-1]) begin
                            if (w_t > r_te) begin
                                r_te <= w_t;
                                if (w_t > r_tl) begin
                                    r_hit <= 1'b0;
                                    r_state <= S_DONE;
                                end else r_state <= S_UPD;
                            end else r_state <= S_UPD;
                        end else begin
                            if (w_t < r_tl) begin
                                r_tl <= w_t;
                                if (w_t < r_te) begin
                                    r_hit <= 1'b0;
                                    r_state <= S_DONE;
                                end else r_state <= S_UPD;
                            end else r_state <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    if (w_last) begin
                        r_hit <= 1'b1;
                        r_pt <= '0;
                        r_state <= S_PMUL;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                        r_rd_addr <= AW'(r_idx + CW'(1));
                        r_state <= S_RD0;
                    end
                end
                S_PMUL: begin
                    r_state <= S_PRND;
                end
                S_PRND: begin
                    r_res[r_pt] <= w_pp[COORD_BITS+QW+2]
                        ? w_base - COORD_BITS'(w_pr) : w_base + COORD_BITS'(w_pr);
                    r_pt <= r_pt + 2'd1;
                    r_state <= (r_pt == 2'd3) ? S_DONE : S_PMUL;
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    o_hit <= r_hit;
                    o_enter_x <= r_hit ? r_res[0] : '0;
                    o_enter_y <= r_hit ? r_res[1] : '0;
                    o_leave_x <= r_hit ? r_res[2] : '0;
                    o_leave_y <= r_hit ? r_res[3] : '0;
                    r_state <= S_OUT;
                end
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/scpc_checker.sv
`include "segment_convex_polygon_clip_macros.svh"
module scpc_checker
    import scpc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic [1:0] i_opcode,
    input logic o_valid
);
    `SCPC_ASSERT(a_strobe_one, i_clk, i_rst_n, o_valid |=> !o_valid, "strobe longer than one cycle")
    `SCPC_ASSERT(a_clip_busy, i_clk, i_rst_n, (start && !busy && i_opcode == OP_CLIP) |=> busy, "clip not busy")
    `SCPC_ASSERT(a_valid_busy, i_clk, i_rst_n, o_valid |-> busy, "result while idle")
    `SCPC_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> !busy && !o_valid, "not idle after reset")
endmodule

bind segment_convex_polygon_clip scpc_checker u_scpc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_opcode(i_opcode), .o_valid(o_valid)
);

### test/segment_convex_polygon_clip_checker.sv
module segment_convex_polygon_clip_checker
    import scpc_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         i_opcode,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_end_x,
    input  logic signed [15:0] i_end_y,
    input  logic               o_valid,
    input  logic               o_hit,
    input  logic signed [15:0] o_enter_x,
    input  logic signed [15:0] o_enter_y,
    input  logic signed [15:0] o_leave_x,
    input  logic signed [15:0] o_leave_y,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
    } clip_result_t;

    logic signed [15:0] poly_x [MAX_VERTICES];
    logic signed [15:0] poly_y [MAX_VERTICES];
    int                 poly_count;
    clip_result_t       expected_clips [$];

    function automatic longint quotient_q16(longint n, longint d);
        longint an, ad, q;
        an = n < 0 ? -n : n;
        ad = d < 0 ? -d : d;
        q = (an * 65536 + ad / 2) / ad;
        if (q > TSat) q = TSat;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic logic signed [15:0] point_at(longint p, longint d, longint t);
        longint prod, r;
        prod = d * t;
        r = ((prod < 0 ? -prod : prod) + 32768) >>> 16;
        return 16'(p + (prod < 0 ? -r : r));
    endfunction

    function automatic clip_result_t clip_segment(longint x0, longint y0,
                                                  longint x1, longint y1);
        clip_result_t res;
        longint te, tl, dx, dy, vx, vy, ex, ey, num, den, t;
        int j;
        res = '0;
        te = 0;
        tl = TOne;
        dx = x1 - x0;
        dy = y1 - y0;
        if (poly_count == 0) return res;
        for (int i = 0; i < poly_count; i++) begin
            j = (i + 1 == poly_count) ? 0 : i + 1;
            vx = poly_x[i];
            vy = poly_y[i];
            ex = longint'(poly_x[j]) - vx;
            ey = longint'(poly_y[j]) - vy;
            num = ex * (y0 - vy) - ey * (x0 - vx);
            den = -(ex * dy - ey * dx);
            if (den == 0) begin
                if (num < 0) return res;
                continue;
            end
            t = quotient_q16(num, den);
            if (den < 0) begin
                if (t > te) begin
                    te = t;
                    if (te > tl) return res;
                end
            end else if (t < tl) begin
                tl = t;
                if (tl < te) return res;
            end
        end
        res.hit = 1'b1;
        res.ex = point_at(x0, dx, te);
        res.ey = point_at(y0, dy, te);
        res.lx = point_at(x0, dx, tl);
        res.ly = point_at(y0, dy, tl);
        return res;
    endfunction

    initial fail_count = 0;
    initial poly_count = 0;
    initial pending = 0;

    always @(posedge i_clk) begin
        clip_result_t want;
        if (!i_rst_n) begin
            poly_count = 0;
        end else begin
            if (o_valid) begin
                if (expected_clips.size() == 0) begin
                    $error("unexpected result");
                    fail_count++;
                end else begin
                    want = expected_clips.pop_front();
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %0d actual %0d", want.hit, o_hit);
                        fail_count++;
                    end
                    if (o_enter_x !== want.ex) begin
                        $error("enter_x: expected %0d actual %0d", want.ex, o_enter_x);
                        fail_count++;
                    end
                    if (o_enter_y !== want.ey) begin
                        $error("enter_y: expected %0d actual %0d", want.ey, o_enter_y);
                        fail_count++;
                    end
                    if (o_leave_x !== want.lx) begin
                        $error("leave_x: expected %0d actual %0d", want.lx, o_leave_x);
                        fail_count++;
                    end
                    if (o_leave_y !== want.ly) begin
                        $error("leave_y: expected %0d actual %0d", want.ly, o_leave_y);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                case (t_opcode'(i_opcode))
                    OP_CLEAR: poly_count = 0;
                    OP_APPEND: begin
                        if (poly_count < MAX_VERTICES) begin
                            poly_x[poly_count] = i_start_x;
                            poly_y[poly_count] = i_start_y;
                            poly_count++;
                        end
                    end
                    OP_CLIP: expected_clips.push_back(clip_segment(i_start_x, i_start_y,
                                                                   i_end_x, i_end_y));
                    default: ;
                endcase
            end
        end
        pending = expected_clips.size();
    end
endmodule

### test/segment_convex_polygon_clip_test.sv
module segment_convex_polygon_clip_test;
    import scpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_opcode;
    logic signed [15:0] i_start_x, i_start_y, i_end_x, i_end_y;
    logic               o_valid, o_hit;
    logic signed [15:0] o_enter_x, o_enter_y, o_leave_x, o_leave_y;
    int                 fail_count;
    int                 pending;
    longint             cycle_count;
    bit                 quiet_phase;

    localparam longint CycleLimit = 5_000_000;

    segment_convex_polygon_clip uut (.*);
    segment_convex_polygon_clip_checker checker_inst (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CycleLimit) begin
                $display("segment_convex_polygon_clip_test: errors");
                $finish;
            end
        end
    end

    // one item: optional idle gap, then hold start until accepted
    task automatic send_item(t_opcode op, int sx, int sy, int ex, int ey);
        while (!quiet_phase && $urandom_range(99) < 28) @(negedge i_clk);
        start = 1'b1;
        i_opcode = op;
        i_start_x = 16'(sx);
        i_start_y = 16'(sy);
        i_end_x = 16'(ex);
        i_end_y = 16'(ey);
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        start = 1'b0;
        i_opcode = 2'($urandom);
        i_start_x = 16'($urandom);
        i_start_y = 16'($urandom);
        i_end_x = 16'($urandom);
        i_end_y = 16'($urandom);
    endtask

    task automatic add_vertex(int x, int y);
        send_item(OP_APPEND, x, y, 16'($urandom), 16'($urandom));
    endtask

    task automatic clip_random_segment(int span);
        send_item(OP_CLIP, $signed($urandom_range(2 * span)) - span,
                  $signed($urandom_range(2 * span)) - span,
                  $signed($urandom_range(2 * span)) - span,
                  $signed($urandom_range(2 * span)) - span);
    endtask

    // convex polygon: points on a circle, counterclockwise
    task automatic build_polygon(int sides, int radius, int cx, int cy);
        real a;
        send_item(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        for (int k = 0; k < sides; k++) begin
            a = 6.283185307 * k / sides;
            add_vertex(cx + $rtoi(radius * $cos(a)), cy + $rtoi(radius * $sin(a)));
        end
    endtask

    initial begin
        int sides;
        quiet_phase = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_opcode = OP_NONE;
        {i_start_x, i_start_y, i_end_x, i_end_y} = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(OP_CLIP, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_item(OP_NONE, 0, 0, 0, 0);
        add_vertex(16, 16);
        send_item(OP_CLIP, 0, 0, 16'sh7fff, 16'sh7fff);
        add_vertex(-16, 16);
        send_item(OP_CLIP, 0, 0, 0, 64);
        send_item(OP_CLIP, 0, 0, 64, 32);
        build_polygon(4, 800, 0, 0);
        send_item(OP_CLIP, -2000, 0, 2000, 0);
        send_item(OP_CLIP, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_item(OP_CLIP, 0, 0, 100, 100);
        send_item(OP_CLIP, -2000, 900, 2000, 900);
        send_item(OP_CLIP, 5, 5, 5, 5);
        build_polygon(4, 16000, 0, 0);
        send_item(OP_CLIP, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        send_item(OP_CLIP, 16'sh8000, 0, 16'sh7fff, 0);
        build_polygon(64, 1000, 0, 0);
        add_vertex(3, 3);
        send_item(OP_CLIP, -3000, 100, 3000, -100);
        while (pending != 0) @(negedge i_clk);

        for (int r = 0; r < 25; r++) begin
            quiet_phase = (r >= 15 && r < 22);
            sides = ($urandom_range(9) == 0) ? 64 : $urandom_range(1, 8);
            build_polygon(sides, $urandom_range(16, 8000),
                          $signed($urandom_range(8000)) - 4000,
                          $signed($urandom_range(8000)) - 4000);
            if ($urandom_range(9) == 0)
                send_item(OP_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom));
            for (int k = 0; k < 6; k++) begin
                if ($urandom_range(5) == 0)
                    send_item(OP_CLIP, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom));
                else
                    clip_random_segment(12000);
            end
            if (r == 20) while (pending != 0) @(negedge i_clk);
        end
        quiet_phase = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("segment_convex_polygon_clip_test: clean");
        end else begin
            $display("segment_convex_polygon_clip_test: errors");
        end
        $finish;
    end
endmodule
